FILE: sv/apa_pkg.sv
package apa_pkg;

  // Field and register widths
  localparam int AltW  = 22;
  localparam int SeaW  = 22;
  localparam int PresW = 22;
  localparam int TempW = 17;
  localparam int DensW = 18;
  localparam int SndW  = 17;
  localparam int MaxW  = 21;
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegSeaPres = 2'd0;
  localparam logic [1:0] RegSeaTemp = 2'd1;
  localparam logic [1:0] RegSeaDens = 2'd2;
  localparam logic [1:0] RegMaxAlt  = 2'd3;

  // Register reset values
  localparam logic [PresW-1:0] SeaPresRst = 22'd1620800;
  localparam logic [TempW-1:0] SeaTempRst = 17'd73769;
  localparam logic [DensW-1:0] SeaDensRst = 18'd80282;
  localparam logic [MaxW-1:0]  MaxAltRst  = 21'd292800;

  // Saturation limits
  localparam logic [PresW-1:0] PresMax = '1;
  localparam logic [TempW-1:0] TempMax = '1;
  localparam logic [DensW-1:0] DensMax = '1;
  localparam logic [SndW-1:0]  SndMax  = '1;

  // Polynomial lanes
  localparam int NumLanes = 3;
  localparam int LanePres = 0;
  localparam int LaneTemp = 1;
  localparam int LaneDens = 2;
  localparam int PolyOrd  = 4;
  localparam int CoefW    = 36;

  typedef logic signed [CoefW-1:0] coef_t;

  // Coefficients in Q24, index is the power of u
  localparam coef_t PolyCoef [NumLanes][PolyOrd+1] = '{
    '{36'sd16777216, -36'sd260454513, 36'sd1636082084, -36'sd5190069659, 36'sd7941286317},
    '{36'sd16777216, -36'sd50074398, 36'sd62854110, -36'sd2157569910, 36'sd19673640210},
    '{36'sd16777216, -36'sd210971432, 36'sd1017793340, -36'sd2204612236, 36'sd1132561631}
  };

  // Scaled quantity before falloff and saturation
  localparam int ScaleW = 34;

  // Falloff divider
  localparam int QuoW   = 22;
  localparam int NumW   = ScaleW + MaxW + 1;
  localparam int DivLat = QuoW + 1;

  // Square root of temperature << 16
  localparam int RootW = 22;
  localparam int RadW  = 2 * RootW - 16;

  // 20.1 in Q16
  localparam int SndKW = 21;
  localparam logic [SndKW-1:0] SoundK = 21'd1317274;

  // Input register to output register
  localparam int TotalLat = 37;

endpackage

FILE: sv/apa_delay.sv
module apa_delay #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] pipe_q [Depth];

  // Shift the word along the line
  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int i = 1; i < Depth; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[Depth-1];

endmodule

FILE: sv/apa_horner.sv
module apa_horner (
  input  logic                              clk_i,
  input  logic signed [apa_pkg::AltW-1:0]   x_i,
  output apa_pkg::coef_t                    poly_o [apa_pkg::NumLanes]
);

  localparam int Steps  = apa_pkg::PolyOrd;
  localparam int ProdW  = apa_pkg::CoefW + apa_pkg::AltW;
  localparam int ShiftW = apa_pkg::AltW - 1;
  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(2 ** (ShiftW - 1));

  logic signed [apa_pkg::AltW-1:0] x_q [2*Steps-2];
  logic signed [apa_pkg::AltW-1:0] xs  [Steps];

  function automatic apa_pkg::coef_t round_shift(input logic signed [ProdW-1:0] m);
    logic signed [ProdW-1:0] s;
    s = (m + RndHalf) >>> ShiftW;
    return apa_pkg::CoefW'(s);
  endfunction

  // Delay x so each step sees its own item
  always_ff @(posedge clk_i) begin
    x_q[0] <= x_i;
    for (int j = 1; j < 2*Steps-2; j++) begin
      x_q[j] <= x_q[j-1];
    end
  end

  always_comb begin
    xs[0] = x_i;
    for (int k = 1; k < Steps; k++) begin
      xs[k] = x_q[2*k-1];
    end
  end

  for (genvar l = 0; l < apa_pkg::NumLanes; l++) begin : g_lane
    logic signed [ProdW-1:0] m_q   [Steps];
    apa_pkg::coef_t          acc_q [Steps];
    apa_pkg::coef_t          mul_a [Steps];

    always_comb begin
      mul_a[0] = apa_pkg::PolyCoef[l][Steps];
      for (int k = 1; k < Steps; k++) begin
        mul_a[k] = acc_q[k-1];
      end
    end

    // Multiply, then round and add the next coefficient
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < Steps; k++) begin
        m_q[k]   <= ProdW'(mul_a[k]) * ProdW'(xs[k]);
        acc_q[k] <= round_shift(m_q[k]) + apa_pkg::PolyCoef[l][Steps-1-k];
      end
    end

    assign poly_o[l] = acc_q[Steps-1];
  end

endmodule

FILE: sv/apa_div.sv
module apa_div (
  input  logic                       clk_i,
  input  logic [apa_pkg::NumW-1:0]   num_i,
  input  logic [apa_pkg::MaxW-1:0]   den_i,
  output logic [apa_pkg::QuoW-1:0]   quo_o,
  output logic                       ovf_o
);

  localparam int QuoW = apa_pkg::QuoW;
  localparam int RemW = apa_pkg::MaxW + QuoW;

  logic [RemW-1:0]         rem_q [QuoW+1];
  logic [apa_pkg::MaxW-1:0] den_q [QuoW+1];
  logic [QuoW-1:0]         quo_q [QuoW+1];
  logic                    ovf_q [QuoW+1];

  // Flag quotients that do not fit, then take one bit per stage
  always_ff @(posedge clk_i) begin
    ovf_q[0] <= num_i >= (apa_pkg::NumW'(den_i) << QuoW);
    rem_q[0] <= RemW'(num_i);
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    for (int j = 1; j <= QuoW; j++) begin
      den_q[j] <= den_q[j-1];
      ovf_q[j] <= ovf_q[j-1];
      if (rem_q[j-1] >= (RemW'(den_q[j-1]) << (QuoW - j))) begin
        rem_q[j] <= rem_q[j-1] - (RemW'(den_q[j-1]) << (QuoW - j));
        quo_q[j] <= {quo_q[j-1][QuoW-2:0], 1'b1};
      end else begin
        rem_q[j] <= rem_q[j-1];
        quo_q[j] <= {quo_q[j-1][QuoW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q[QuoW];
  assign ovf_o = ovf_q[QuoW];

endmodule

FILE: sv/apa_sqrt.sv
module apa_sqrt (
  input  logic                       clk_i,
  input  logic [apa_pkg::RadW-1:0]   val_i,
  output logic [apa_pkg::RootW-1:0]  root_o
);

  localparam int RootW = apa_pkg::RootW;
  localparam int VW    = 2 * RootW;
  localparam int RemW  = RootW + 3;

  logic [VW-1:0]    rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  logic [VW-1:0]    rad_in  [RootW];
  logic [RemW-1:0]  rem_in  [RootW];
  logic [RootW-1:0] root_in [RootW];
  logic [VW-1:0]    rad_d   [RootW];
  logic [RemW-1:0]  rem_d   [RootW];
  logic [RootW-1:0] root_d  [RootW];
  logic [RemW-1:0]  rem_t   [RootW];
  logic [RemW-1:0]  trial   [RootW];

  // One root bit per stage from two radicand bits
  always_comb begin
    rad_in[0]  = {val_i, 16'd0};
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int j = 1; j < RootW; j++) begin
      rad_in[j]  = rad_q[j-1];
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
    end
    for (int j = 0; j < RootW; j++) begin
      rem_t[j] = {rem_in[j][RemW-3:0], rad_in[j][VW-1 -: 2]};
      trial[j] = RemW'({root_in[j], 2'b01});
      rad_d[j] = {rad_in[j][VW-3:0], 2'b00};
      if (rem_t[j] >= trial[j]) begin
        rem_d[j]  = rem_t[j] - trial[j];
        root_d[j] = {root_in[j][RootW-2:0], 1'b1};
      end else begin
        rem_d[j]  = rem_t[j];
        root_d[j] = {root_in[j][RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < RootW; j++) begin
      rad_q[j]  <= rad_d[j];
      rem_q[j]  <= rem_d[j];
      root_q[j] <= root_d[j];
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

FILE: sv/atmosphere_profile_by_altitude.sv
// Standard atmosphere profile by altitude.
// Input channel: drive altitude_i (signed, 1/16 m) with start high; the word
// is taken at that edge whenever busy is low, and busy is always low, so a
// new altitude may enter in every cycle.
// Result channel: valid_o is high for exactly one cycle with pressure_o,
// air_temperature_o, density_o and sound_speed_o; the receiver must take
// the word in that cycle. Results leave in input order.
// Throughput: one word per cycle. The path runs through the clamp stage,
// four Horner steps (each a multiply register, then a round/add register),
// two scale stages, two falloff numerator stages, the 23-stage falloff
// divider (an overflow check, then one quotient bit per stage) and the
// output register; the 22-stage square root and sound speed stages run
// beside the divider.
// Configuration: APB port, registers at byte 0 (sea pressure), 4 (sea
// temperature), 8 (sea density), 12 (max altitude); pready is always high.
// Write registers only while no word is in flight.
// Reset: rst_ni low clears the valid line and loads the standard sea-level
// values and the default max altitude; words in flight are dropped.
module atmosphere_profile_by_altitude (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apa_pkg::AddrW-1:0]         paddr,
  input  logic [apa_pkg::DataW-1:0]         pwdata,
  output logic [apa_pkg::DataW-1:0]         prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [apa_pkg::AltW-1:0]   altitude_i,
  output logic                              valid_o,
  output logic [apa_pkg::PresW-1:0]         pressure_o,
  output logic [apa_pkg::TempW-1:0]         air_temperature_o,
  output logic [apa_pkg::DensW-1:0]         density_o,
  output logic [apa_pkg::SndW-1:0]          sound_speed_o
);

  localparam int NumLanes = apa_pkg::NumLanes;
  localparam int SProdW   = apa_pkg::SeaW + apa_pkg::CoefW - 1;
  localparam int FProdW   = apa_pkg::ScaleW + apa_pkg::MaxW;
  localparam int SMulW    = apa_pkg::RootW + apa_pkg::SndKW;
  localparam int SatW     = apa_pkg::PresW + apa_pkg::DensW + apa_pkg::TempW;
  localparam int HDlyW    = apa_pkg::AltW + 1;

  // Configuration registers
  logic [apa_pkg::PresW-1:0] sea_pres_q;
  logic [apa_pkg::TempW-1:0] sea_temp_q;
  logic [apa_pkg::DensW-1:0] sea_dens_q;
  logic [apa_pkg::MaxW-1:0]  max_alt_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sea_pres_q <= apa_pkg::SeaPresRst;
      sea_temp_q <= apa_pkg::SeaTempRst;
      sea_dens_q <= apa_pkg::SeaDensRst;
      max_alt_q  <= apa_pkg::MaxAltRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        apa_pkg::RegSeaPres: sea_pres_q <= pwdata[apa_pkg::PresW-1:0];
        apa_pkg::RegSeaTemp: sea_temp_q <= pwdata[apa_pkg::TempW-1:0];
        apa_pkg::RegSeaDens: sea_dens_q <= pwdata[apa_pkg::DensW-1:0];
        apa_pkg::RegMaxAlt:  max_alt_q  <= pwdata[apa_pkg::MaxW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      apa_pkg::RegSeaPres: prdata = apa_pkg::DataW'(sea_pres_q);
      apa_pkg::RegSeaTemp: prdata = apa_pkg::DataW'(sea_temp_q);
      apa_pkg::RegSeaDens: prdata = apa_pkg::DataW'(sea_dens_q);
      apa_pkg::RegMaxAlt:  prdata = apa_pkg::DataW'(max_alt_q);
    endcase
  end

  // Valid line
  logic [apa_pkg::TotalLat:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[apa_pkg::TotalLat-1:1], start && !busy};
    end
  end

  assign valid_o = vld_q[apa_pkg::TotalLat];

  // Stage 1: clamp altitude
  logic signed [apa_pkg::AltW-1:0] h_q, x_q;
  logic                            above_q;
  logic                            above_in;

  assign above_in = altitude_i > $signed({1'b0, max_alt_q});

  always_ff @(posedge clk_i) begin
    h_q     <= altitude_i;
    above_q <= above_in;
    x_q     <= above_in ? $signed({1'b0, max_alt_q}) : altitude_i;
  end

  // Stages 2..9: polynomials
  apa_pkg::coef_t poly [NumLanes];

  apa_horner u_horner (
    .clk_i  (clk_i),
    .x_i    (x_q),
    .poly_o (poly)
  );

  // Stages 10..11: scale by the sea-level values
  logic [apa_pkg::SeaW-1:0]   sea_ext [NumLanes];
  logic [SProdW-1:0]          sprod_q [NumLanes];
  logic [apa_pkg::ScaleW-1:0] t_q     [NumLanes];
  logic [SProdW-1:0]          pclip   [NumLanes];
  logic [SProdW:0]            srnd    [NumLanes];

  always_comb begin
    sea_ext[apa_pkg::LanePres] = sea_pres_q;
    sea_ext[apa_pkg::LaneTemp] = apa_pkg::SeaW'(sea_temp_q);
    sea_ext[apa_pkg::LaneDens] = apa_pkg::SeaW'(sea_dens_q);
    for (int l = 0; l < NumLanes; l++) begin
      // Drop non-positive polynomial values to zero
      if (poly[l][apa_pkg::CoefW-1] || poly[l] == '0) begin
        pclip[l] = '0;
      end else begin
        pclip[l] = SProdW'(poly[l][apa_pkg::CoefW-2:0]);
      end
      srnd[l] = (SProdW+1)'(sprod_q[l]) + (SProdW+1)'(2 ** 23);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      sprod_q[l] <= SProdW'(sea_ext[l]) * pclip[l];
      t_q[l]     <= srnd[l][24 +: apa_pkg::ScaleW];
    end
  end

  // Saturated values for the plain (not above max) case
  logic [apa_pkg::PresW-1:0] psat;
  logic [apa_pkg::TempW-1:0] tsat;
  logic [apa_pkg::DensW-1:0] dsat;
  logic [SatW-1:0]           sat_dly;

  always_comb begin
    psat = (t_q[apa_pkg::LanePres] > apa_pkg::ScaleW'(apa_pkg::PresMax)) ?
           apa_pkg::PresMax : t_q[apa_pkg::LanePres][apa_pkg::PresW-1:0];
    tsat = (t_q[apa_pkg::LaneTemp] > apa_pkg::ScaleW'(apa_pkg::TempMax)) ?
           apa_pkg::TempMax : t_q[apa_pkg::LaneTemp][apa_pkg::TempW-1:0];
    dsat = (t_q[apa_pkg::LaneDens] > apa_pkg::ScaleW'(apa_pkg::DensMax)) ?
           apa_pkg::DensMax : t_q[apa_pkg::LaneDens][apa_pkg::DensW-1:0];
  end

  apa_delay #(.Width(SatW), .Depth(25)) u_sat_dly (
    .clk_i (clk_i),
    .d_i   ({psat, dsat, tsat}),
    .q_o   (sat_dly)
  );

  // Altitude and falloff flag to stage 12, flag on to stage 36
  logic [HDlyW-1:0]                h_dly;
  logic signed [apa_pkg::AltW-1:0] h12;
  logic                            above12;
  logic                            above36;

  apa_delay #(.Width(HDlyW), .Depth(11)) u_h_dly (
    .clk_i (clk_i),
    .d_i   ({above_q, h_q}),
    .q_o   (h_dly)
  );

  assign above12 = h_dly[HDlyW-1];
  assign h12     = h_dly[apa_pkg::AltW-1:0];

  apa_delay #(.Width(1), .Depth(24)) u_above_dly (
    .clk_i (clk_i),
    .d_i   (above12),
    .q_o   (above36)
  );

  // Stages 12..13: falloff numerator and divisor
  logic [FProdW-1:0]        fp_q, fd_q;
  logic [apa_pkg::NumW-1:0] num_p_q, num_d_q;
  logic [apa_pkg::MaxW-1:0] den_q;
  logic [apa_pkg::NumW-1:0] half_h;

  assign half_h = apa_pkg::NumW'(h12[apa_pkg::AltW-2:1]);

  always_ff @(posedge clk_i) begin
    fp_q    <= FProdW'(t_q[apa_pkg::LanePres]) * FProdW'(max_alt_q);
    fd_q    <= FProdW'(t_q[apa_pkg::LaneDens]) * FProdW'(max_alt_q);
    num_p_q <= apa_pkg::NumW'(fp_q) + half_h;
    num_d_q <= apa_pkg::NumW'(fd_q) + half_h;
    den_q   <= above12 ? h12[apa_pkg::MaxW-1:0] : apa_pkg::MaxW'(1);
  end

  // Stages 14..36: dividers
  logic [apa_pkg::QuoW-1:0] quo_p, quo_d;
  logic                     ovf_p, ovf_d;

  apa_div u_div_pres (
    .clk_i (clk_i),
    .num_i (num_p_q),
    .den_i (den_q),
    .quo_o (quo_p),
    .ovf_o (ovf_p)
  );

  apa_div u_div_dens (
    .clk_i (clk_i),
    .num_i (num_d_q),
    .den_i (den_q),
    .quo_o (quo_d),
    .ovf_o (ovf_d)
  );

  // Stages 12..33: square root of temperature
  logic [apa_pkg::RootW-1:0] root;

  apa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .val_i  (t_q[apa_pkg::LaneTemp][apa_pkg::RadW-1:0]),
    .root_o (root)
  );

  // Stages 34..36: sound speed
  logic [SMulW-1:0]        smul_q;
  logic [SMulW:0]          srnd_s;
  logic [apa_pkg::SndW-1:0] snd_q, snd36;

  assign srnd_s = (SMulW+1)'(smul_q) + (SMulW+1)'(2 ** 19);

  always_ff @(posedge clk_i) begin
    smul_q <= SMulW'(root) * SMulW'(apa_pkg::SoundK);
    snd_q  <= (srnd_s[SMulW:20] > (SMulW-19)'(apa_pkg::SndMax)) ?
              apa_pkg::SndMax : srnd_s[20 +: apa_pkg::SndW];
  end

  apa_delay #(.Width(apa_pkg::SndW), .Depth(1)) u_snd_dly (
    .clk_i (clk_i),
    .d_i   (snd_q),
    .q_o   (snd36)
  );

  // Stage 37: pick falloff or plain value, register the result word
  logic [apa_pkg::PresW-1:0] pres_d;
  logic [apa_pkg::DensW-1:0] dens_d;

  always_comb begin
    if (above36) begin
      pres_d = ovf_p ? apa_pkg::PresMax : quo_p;
      dens_d = (ovf_d || quo_d > apa_pkg::QuoW'(apa_pkg::DensMax)) ?
               apa_pkg::DensMax : quo_d[apa_pkg::DensW-1:0];
    end else begin
      pres_d = sat_dly[SatW-1 -: apa_pkg::PresW];
      dens_d = sat_dly[apa_pkg::TempW +: apa_pkg::DensW];
    end
  end

  always_ff @(posedge clk_i) begin
    pressure_o        <= pres_d;
    density_o         <= dens_d;
    air_temperature_o <= sat_dly[apa_pkg::TempW-1:0];
    sound_speed_o     <= snd36;
  end

endmodule

FILE: sv/apa_checker.sv
module apa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [apa_pkg::AddrW-1:0]         paddr,
  input logic [apa_pkg::DataW-1:0]         pwdata,
  input logic [apa_pkg::DataW-1:0]         prdata,
  input logic                              pready,
  input logic                              start,
  input logic                              busy,
  input logic signed [apa_pkg::AltW-1:0]   altitude_i,
  input logic                              valid_o,
  input logic [apa_pkg::PresW-1:0]         pressure_o,
  input logic [apa_pkg::TempW-1:0]         air_temperature_o,
  input logic [apa_pkg::DensW-1:0]         density_o,
  input logic [apa_pkg::SndW-1:0]          sound_speed_o
);

  // Every result word comes from a word taken a fixed latency earlier
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, apa_pkg::TotalLat))
    else $error("result word without a matching input word");

  // Zero temperature means zero sound speed
  a_cold_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && air_temperature_o == '0) |-> sound_speed_o == '0)
    else $error("sound speed nonzero at zero temperature");

  // A written sea pressure reads back masked to its width
  a_pres_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(psel && penable && pwrite && pready) && $past(paddr[3:2]) == apa_pkg::RegSeaPres
     && paddr[3:2] == apa_pkg::RegSeaPres)
    |-> (prdata[apa_pkg::PresW-1:0] == $past(pwdata[apa_pkg::PresW-1:0])
         && prdata[apa_pkg::DataW-1:apa_pkg::PresW] == '0))
    else $error("sea pressure readback mismatch");

  // The port never inserts wait states
  a_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable) |-> pready)
    else $error("wait state on configuration port");

endmodule

bind atmosphere_profile_by_altitude apa_checker u_apa_checker (.*);
